// ===== rtl/kcv_pkg.sv =====
// Shared constants and helpers of the constant-velocity Kalman tracker.
package kcv_pkg;

  localparam int VW = 32;
  localparam int FB = 16;
  localparam int CFG_W = 31;

  localparam logic signed [VW-1:0] ONE_FX = VW'(64'sd1 <<< FB);
  localparam logic signed [VW-1:0] HALF_FX = VW'(64'sd1 <<< (FB - 1));
  localparam logic signed [VW-1:0] HUNDREDTH = VW'(((64'sd1 <<< FB) + 50) / 100);
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  localparam logic [1:0] KIND_INIT = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_PREDICT = 2'd2;

  localparam logic [1:0] REG_Q_POSITION = 2'd0;
  localparam logic [1:0] REG_Q_VELOCITY = 2'd1;
  localparam logic [1:0] REG_R_MEASUREMENT = 2'd2;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NO_INIT = 1'b1;

  typedef logic signed [VW-1:0] value_t;

  // Magnitude of a signed value, exact for the most negative one.
  function automatic logic [VW-1:0] mag(input value_t a);
    mag = a[VW-1] ? (~a + VW'(1)) : a;
  endfunction

  // Saturate a wider signed sum into the value range.
  function automatic value_t sat(input logic signed [VW+1:0] v);
    if (v > $signed({2'b00, VMAX})) sat = VMAX;
    else if (v < $signed({2'b11, VMIN})) sat = VMIN;
    else sat = v[VW-1:0];
  endfunction

endpackage

// ===== rtl/kcv_gain_div.sv =====
// Bit-serial gain divider with clamping of the quotient.
module kcv_gain_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  kcv_pkg::value_t num,
  input  kcv_pkg::value_t den,
  output logic           done,
  output kcv_pkg::value_t gain
);
  import kcv_pkg::*;

  localparam int CW = $clog2(FB + 1);

  logic [VW:0]   md;
  logic [VW:0]   rem;
  logic [FB-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          neg;
  logic [VW:0]   diff;
  logic [VW:0]   mn_w;
  logic [VW:0]   md_w;
  value_t        clamped;

  assign mn_w = {1'b0, mag(num)};
  assign md_w = {1'b0, mag(den)};
  assign diff = md - rem;

  always_comb begin
    if ({1'b0, quo} < (FB+1)'(HUNDREDTH)) clamped = HUNDREDTH;
    else if ({1'b0, quo} > (FB+1)'(HALF_FX)) clamped = HALF_FX;
    else if (neg) clamped = -$signed({{(VW-FB){1'b0}}, quo});
    else clamped = $signed({{(VW-FB){1'b0}}, quo});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[VW-1] ^ den[VW-1];
        md  <= md_w;
        rem <= mn_w;
        quo <= '0;
        cnt <= '0;
        if (den == '0 || mn_w >= md_w) begin
          gain <= HALF_FX;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == CW'(FB)) begin
          gain <= clamped;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          // one quotient bit per cycle
          if (rem >= diff) begin
            rem <= rem - diff;
            quo <= {quo[FB-2:0], 1'b1};
          end else begin
            rem <= rem + rem;
            quo <= {quo[FB-2:0], 1'b0};
          end
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> !(busy && done))
    else $error("divider reports done while still iterating");
  assert property (@(posedge clk) disable iff (rst) busy && cnt != CW'(FB) |=> !done)
    else $error("divider finished early");
  assert property (@(posedge clk) disable iff (rst) done |-> (gain != '0))
    else $error("gain must be clamped away from zero");

endmodule

// ===== rtl/kalman_1d_const_velocity.sv =====
// Top level of the two-state constant-velocity Kalman tracker.
//
// Usage:
//  Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser carries the
//  item kind (init, update, predict). Each word yields exactly one result word
//  on m_tvalid/m_tready/m_tdata/m_tuser, with the status flag in m_tuser.
//  The user must write the noise registers through cfg_we/cfg_index/cfg_data
//  only while idle; the block itself does not enforce this. Init, early update
//  and unknown kinds go from idle straight to the output state; predict first
//  runs a single multiply-accumulate step (MUL then ADD state); a full update
//  runs fifteen such steps on the one shared multiplier plus two gain divisions
//  (16 quotient bits each) on the shared bit-serial divider; a division that
//  clamps to one half at once skips the quotient iteration.
//  s_tready is high only while the sequencer is idle, one word at a time.
//  A finished result sits in the output register; the block takes the next
//  word while it waits, and a later result holds in the sequencer until the
//  receiver takes the earlier one.
//  Reset (rst, synchronous) clears the track to the uninitialized state,
//  covariance to identity and all noise registers to 1.0.
//  Values are signed Q16.16; every product and sum saturates.
module kalman_1d_const_velocity (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // measurement[31:0], time_stamp[63:32], horizon[95:64]
  input  logic [1:0]  s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // position[31:0], velocity[63:32]
  output logic        m_tuser,  // status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import kcv_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_ADD    = 3'd2;
  localparam logic [2:0] ST_DSTART = 3'd3;
  localparam logic [2:0] ST_DWAIT  = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  localparam logic [3:0] OP_PRED = 4'd0;
  localparam logic [3:0] OP_S    = 4'd8;
  localparam logic [3:0] OP_Y    = 4'd9;
  localparam logic [3:0] OP_LAST = 4'd15;

  logic [2:0] state;
  logic [3:0] opstep;
  logic       divsel;

  logic [CFG_W-1:0] q_position, q_velocity, r_measurement;
  value_t pos, vel, pp, pv, vp, vv;
  logic [VW-1:0] last_time;
  logic initialized;

  value_t z, hz, dt, xp, a, b, p10, p00, p11, s, y, k0, k1;
  logic [VW-1:0] ts;

  logic [2*VW-1:0] prod;
  logic            prod_neg;
  value_t opa, opb, opc;
  logic   op_sub;
  value_t acc;

  value_t res_pos, res_vel;
  logic   res_status;

  logic   div_start, div_done;
  value_t div_gain;

  logic signed [VW:0] dt_raw;

  assign s_tready = (state == ST_IDLE);
  assign div_start = (state == ST_DSTART);
  assign dt_raw = $signed({1'b0, s_tdata[63:32]}) - $signed({1'b0, last_time});

  kcv_gain_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (divsel ? p10 : p00),
    .den   (s),
    .done  (div_done),
    .gain  (div_gain)
  );

  // operand select for dst = c +/- a*b
  always_comb begin
    op_sub = 1'b0;
    case (opstep)
      4'd1:    begin opa = dt;  opb = vel;    opc = pos; end
      4'd2:    begin opa = dt;  opb = vp;     opc = pp;  end
      4'd3:    begin opa = dt;  opb = vv;     opc = pv;  end
      4'd4:    begin opa = dt;  opb = vv;     opc = vp;  end
      4'd5:    begin opa = dt;  opb = b;      opc = a;   end
      4'd6:    begin opa = $signed({1'b0, q_position}); opb = ONE_FX; opc = p00; end
      4'd7:    begin opa = $signed({1'b0, q_velocity}); opb = ONE_FX; opc = vv;  end
      4'd8:    begin opa = $signed({1'b0, r_measurement}); opb = ONE_FX; opc = p00; end
      4'd9:    begin opa = ONE_FX; opb = xp;  opc = z;   op_sub = 1'b1; end
      4'd10:   begin opa = k0;  opb = y;      opc = xp;  end
      4'd11:   begin opa = k1;  opb = y;      opc = vel; end
      4'd12:   begin opa = k0;  opb = p00;    opc = p00; op_sub = 1'b1; end
      4'd13:   begin opa = k0;  opb = b;      opc = b;   op_sub = 1'b1; end
      4'd14:   begin opa = k1;  opb = p00;    opc = p10; op_sub = 1'b1; end
      4'd15:   begin opa = k1;  opb = b;      opc = p11; op_sub = 1'b1; end
      default: begin opa = vel; opb = hz;     opc = pos; end
    endcase
  end

  // scale, saturate and accumulate the registered product
  always_comb begin
    logic [VW+15:0] q;
    logic [VW:0]    lim;
    logic [VW:0]    m;
    logic signed [VW+1:0] v;
    q = prod[2*VW-1:FB];
    lim = prod_neg ? {2'b01, {(VW-1){1'b0}}} : {2'b00, {(VW-1){1'b1}}};
    m = ((VW+16)'(lim) < q) ? lim : q[VW:0];
    v = prod_neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    acc = op_sub ? sat($signed({{2{opc[VW-1]}}, opc}) - v)
                 : sat($signed({{2{opc[VW-1]}}, opc}) + v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      opstep <= OP_PRED;
      divsel <= 1'b0;
      m_tvalid <= 1'b0;
      q_position <= CFG_W'(ONE_FX);
      q_velocity <= CFG_W'(ONE_FX);
      r_measurement <= CFG_W'(ONE_FX);
      pos <= '0;
      vel <= '0;
      pp <= ONE_FX;
      pv <= '0;
      vp <= '0;
      vv <= ONE_FX;
      last_time <= '0;
      initialized <= 1'b0;
    end else begin
      // load a new result or drop the taken one
      if (state == ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_Q_POSITION:    q_position <= cfg_data;
          REG_Q_VELOCITY:    q_velocity <= cfg_data;
          REG_R_MEASUREMENT: r_measurement <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            z  <= s_tdata[31:0];
            ts <= s_tdata[63:32];
            hz <= s_tdata[95:64];
            res_pos <= pos;
            res_vel <= vel;
            res_status <= STATUS_OK;
            state <= ST_OUT;
            case (s_tuser)
              KIND_INIT: begin
                pos <= s_tdata[31:0];
                vel <= '0;
                pp <= ONE_FX;
                pv <= '0;
                vp <= '0;
                vv <= ONE_FX;
                last_time <= s_tdata[63:32];
                initialized <= 1'b1;
                res_pos <= s_tdata[31:0];
                res_vel <= '0;
              end
              KIND_UPDATE: begin
                if (!initialized) begin
                  res_status <= STATUS_NO_INIT;
                end else begin
                  // fall back to a hundredth of a second for a non-positive dt
                  if (dt_raw <= 0) dt <= HUNDREDTH;
                  else if (dt_raw > $signed({1'b0, VMAX})) dt <= VMAX;
                  else dt <= dt_raw[VW-1:0];
                  opstep <= 4'd1;
                  state <= ST_MUL;
                end
              end
              KIND_PREDICT: begin
                opstep <= OP_PRED;
                state <= ST_MUL;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          prod <= mag(opa) * mag(opb);
          prod_neg <= opa[VW-1] ^ opb[VW-1];
          state <= ST_ADD;
        end
        ST_ADD: begin
          case (opstep)
            4'd1:  xp <= acc;
            4'd2:  a <= acc;
            4'd3:  b <= acc;
            4'd4:  p10 <= acc;
            4'd5:  p00 <= acc;
            4'd6:  p00 <= acc;
            4'd7:  p11 <= acc;
            4'd8:  s <= acc;
            4'd9:  y <= acc;
            4'd10: pos <= acc;
            4'd11: vel <= acc;
            4'd12: pp <= acc;
            4'd13: pv <= acc;
            4'd14: vp <= acc;
            4'd15: vv <= acc;
            default: res_pos <= acc;
          endcase
          if (opstep == OP_PRED) begin
            state <= ST_OUT;
          end else if (opstep == OP_S) begin
            divsel <= 1'b0;
            state <= ST_DSTART;
          end else if (opstep == OP_LAST) begin
            last_time <= ts;
            res_pos <= pos;
            res_vel <= vel;
            state <= ST_OUT;
          end else begin
            opstep <= opstep + 4'd1;
            state <= ST_MUL;
          end
        end
        ST_DSTART: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            if (!divsel) begin
              k0 <= div_gain;
              divsel <= 1'b1;
              state <= ST_DSTART;
            end else begin
              k1 <= div_gain;
              opstep <= OP_Y;
              state <= ST_MUL;
            end
          end
        end
        ST_OUT: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata <= {res_vel, res_pos};
            m_tuser <= res_status;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while busy");
  assert property (@(posedge clk) disable iff (rst) div_start |-> state != ST_IDLE)
    else $error("divider started outside an update");
  assert property (@(posedge clk) $past(rst) |-> !initialized)
    else $error("track initialized out of reset");

endmodule
